// ===== hdl/tgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, command constants and the 5x8 glyph table of the text glyph
// column stream.
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int FIRST_CODE    = 32;
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_COUNT   = 224;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] NIBBLE_LO  = 8'h0F;

    typedef logic [GLYPH_COLUMNS*8-1:0] t_glyph;

    // sequencer steps of one request
    localparam logic [3:0] STEP_PAGE   = 4'd0;
    localparam logic [3:0] STEP_COL_LO = 4'd1;
    localparam logic [3:0] STEP_COL_HI = 4'd2;
    localparam logic [3:0] STEP_DATA   = 4'd3;
    localparam logic [3:0] STEP_SPACER = 4'(3 + GLYPH_COLUMNS);

    typedef struct packed {
        t_glyph glyph;
        logic   bad;
    } t_lookup;

    // first column in the top byte
    localparam t_glyph FONT [GLYPH_COUNT] = '{
        40'h0000000000, 40'h0000F20000, 40'h00E000E000, 40'h28FE28FE28,
        40'h2454FE5448, 40'hC6C81026C6, 40'h6C92AA440A, 40'h00A0C00000,
        40'h3844820000, 40'h0000824438, 40'h28107C1028, 40'h10107C1010,
        40'h00000A0C00, 40'h1010101010, 40'h0000020000, 40'h0408102040,
        40'h7C8A92A27C, 40'h0042FE0200, 40'h42868A9262, 40'h8482A2D28C,
        40'h182848FE08, 40'hE4A2A2A29C, 40'h3C5292920C, 40'h808E90A0C0,
        40'h6C9292926C, 40'h6092929478, 40'h00006C6C00, 40'h00006A6C00,
        40'h1028448200, 40'h2828282828, 40'h0082442810, 40'h40808A9060,
        40'h4C929C423C, 40'h7E8888887E, 40'hFE9292926C, 40'h7C82828244,
        40'hFE82824438, 40'hFE92929282, 40'hFE90909080, 40'h7C8292925E,
        40'hFE101010FE, 40'h0082FE8200, 40'h040282FC80, 40'hFE10284482,
        40'hFE02020202, 40'hFE402040FE, 40'hFE201008FE, 40'h7C8282827C,
        40'hFE90909060, 40'h7C828A847A, 40'hFE90989462, 40'h629292928C,
        40'h8080FE8080, 40'hFC020202FC, 40'hF8040204F8, 40'hFC021C02FC,
        40'hC6281028C6, 40'hE0101E10E0, 40'h868A92A2C2, 40'h00FE828200,
        40'h18247E2418, 40'h008282FE00, 40'h2040804020, 40'h0202020202,
        40'h0000804000, 40'h042A2A2A1E, 40'hFE1222221C, 40'h1C22222204,
        40'h1C222212FE, 40'h1C2A2A2A18, 40'h107E908040, 40'h102A2A2A3C,
        40'hFE1020201E, 40'h0022BE0200, 40'h040222BC00, 40'h00FE081422,
        40'h0082FE0200, 40'h3E2018201E, 40'h3E1020201E, 40'h1C2222221C,
        40'h3E28282810, 40'h102828283E, 40'h3E10202010, 40'h122A2A2A24,
        40'h20FC220204, 40'h3C0202043E, 40'h3804020438, 40'h3C020C023C,
        40'h2214081422, 40'h300A0A0A30, 40'h22262A3222, 40'h00106C8200,
        40'h0000FE0000, 40'h00826C1000, 40'h0810100808,
        40'hFF80808080, 40'h8080808080, 40'h8080FF8080, 40'h80808080FF,
        40'hFF00000000, 40'h0000FF0000, 40'h00000000FF, 40'hFF10101010,
        40'h1010101010, 40'h1010FF1010, 40'h10101010FF, 40'hFF10101010,
        40'h1010101010, 40'h1010FF1010, 40'h10101010FF, 40'hFF80BFA0A0,
        40'hA0A0A0A0A0, 40'hA0BF80BFA0, 40'hA0A0BF80FF, 40'hFF00FF0000,
        40'h00FF00FF00, 40'h0000FF00FF, 40'hFF00EF2828, 40'h2828282828,
        40'h28EF00EF28, 40'h2828EF00FF, 40'hFF01FD0505, 40'h0505050505,
        40'h05FD01FD05, 40'h0505FD01FF,
        40'h00003E223E, 40'h000000003E, 40'h00002E2A3A, 40'h00002A2A3E,
        40'h000038083E, 40'h00003A2A2E, 40'h00003E2A2E, 40'h000020203E,
        40'h00003E2A3E, 40'h82BAAA92BA, 40'h8A8A82BA82, 40'h8854228822,
        40'hAAAAAAAAAA, 40'h1020101020, 40'h2040FE4020,
        40'h0804FE0408, 40'h1010543810, 40'h1038541010, 40'h0007081324,
        40'h2828282828, 40'h2828130807, 40'h00FF00FF00, 40'h0000FF00FF,
        40'h00E010C824, 40'h1424C810E0, 40'h1414141414, 40'h10387CFE00,
        40'h00FE7C3810, 40'h0878FC7808,
        40'h63251818A4, 40'h7E4242427E, 40'h7E7E7E7E7E, 40'h300C300C30,
        40'h80FF0101FF, 40'h6090906000,
        40'h7E8888887E, 40'hFE9292920C, 40'hFE9292926C, 40'hFE808080C0,
        40'h078AF282FF, 40'hFE92929282, 40'hEE10FE10EE, 40'h929292926C,
        40'hFE081020FE, 40'h3E8448903E, 40'hFE10284482, 40'h0482FC80FE,
        40'hFE402040FE, 40'hFE101010FE, 40'h7C8282827C, 40'hFE808080FE,
        40'hFE90909060, 40'h7C82828244, 40'h8080FE8080, 40'hE2140810E0,
        40'h1824FE2418, 40'hC6281028C6,
        40'hFE020202FF, 40'hE0101010FE, 40'hFE02FE02FE, 40'hFE02FE02FF,
        40'h80FE12120C, 40'hFE120C00FE, 40'hFE1212120C, 40'h448292927C,
        40'hFE107C827C, 40'h62949890FE, 40'h042A2A2A1E, 40'h3C5252928C,
        40'h3E2A2A1400, 40'h3E20202030,
        40'h072A32223F, 40'h1C2A2A2A18, 40'h36083E0836, 40'h22222A2A14,
        40'h3E0408103E, 40'h1E4224481E, 40'h3E08142200, 40'h04223C203E,
        40'h3E1008103E, 40'h3E0808083E, 40'h1C2222221C, 40'h3E2020203E,
        40'h3E28282810, 40'h1C22222204,
        40'h20203E2020, 40'h300A0A0A3C, 40'h3844FE4438, 40'h2214081422,
        40'h3E0202023F, 40'h300808083E, 40'h3E023E023E, 40'h3E023E023F,
        40'h203E0A0A04, 40'h3E0A04003E, 40'h3E0A0A0400, 40'h14222A2A1C,
        40'h3E081C221C, 40'h102A2C283E
    };

endpackage
`default_nettype wire

// ===== hdl/tgc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_in_if
// Character request channel: code, page, column and reposition flag.
// ----------------------------------------------------------------------------
interface tgc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [3:0] page_addr;
    logic [7:0] column_addr;
    logic       reposition;

    modport source (output valid, char_code, page_addr, column_addr, reposition,
                    input ready);
    modport sink   (input valid, char_code, page_addr, column_addr, reposition,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/tgc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_out_if
// Byte channel toward the display controller.
// ----------------------------------------------------------------------------
interface tgc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_command;
    logic       bad_code;
    logic       last_of_run;

    modport source (output valid, out_byte, is_command, bad_code, last_of_run,
                    input ready);
    modport sink   (input valid, out_byte, is_command, bad_code, last_of_run,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/tgc_glyph_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_glyph_rom
// Maps a character code to its glyph columns and flags codes outside the font.
// ----------------------------------------------------------------------------
module tgc_glyph_rom
    import tgc_pkg::*;
(
    input  wire logic [7:0] i_code,
    output t_lookup         o_lookup
);

    logic [8:0] idx;
    logic       bad;

    always_comb begin
        idx = {1'b0, i_code} - 9'(FIRST_CODE);
        bad = (i_code < 8'(FIRST_CODE)) || (idx >= 9'(GLYPH_COUNT));
        o_lookup.bad = bad;
        // blank columns for codes outside the table
        o_lookup.glyph = bad ? '0 : FONT[idx[7:0]];
    end

endmodule
`default_nettype wire

// ===== hdl/text_glyph_column_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_glyph_column_stream
// Turns character requests into the command and data bytes of a page-addressed
// LCD controller.
// ----------------------------------------------------------------------------
// Each request yields one byte per cycle while the sink is ready; the byte
// sequencer gives three page/column commands when reposition is set, then
// five bit-reversed glyph columns and a zero spacer flagged last_of_run, so
// a request gives 9 bytes with reposition and 6 without. The next request
// is taken in the cycle its predecessor's spacer moves into the output
// register, so bytes flow without gaps while the sink is ready. Codes outside
// the font give blank columns with bad_code high on every byte of the request.
// ----------------------------------------------------------------------------
module text_glyph_column_stream
    import tgc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tgc_in_if.sink      i_in,
    tgc_out_if.source   o_out
);

    t_lookup    lookup;

    logic       r_busy;
    logic [3:0] r_step;
    logic [3:0] r_page;
    logic [7:0] r_col;
    t_glyph     r_glyph;
    logic       r_bad;

    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_cmd;
    logic       r_obad;
    logic       r_last;

    logic       out_load;
    logic       at_last;
    logic       accept;
    logic [7:0] n_byte;
    logic       n_cmd;
    logic [3:0] data_idx;
    logic [7:0] column;

    tgc_glyph_rom u_rom (
        .i_code   (i_in.char_code),
        .o_lookup (lookup)
    );

    assign out_load   = r_busy && (!r_ov || o_out.ready);
    assign at_last    = (r_step == STEP_SPACER);
    assign i_in.ready = !r_busy || (out_load && at_last);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        data_idx = r_step - STEP_DATA;
        column   = r_glyph[(GLYPH_COLUMNS - 1 - int'(data_idx[2:0])) * 8 +: 8];
        n_byte   = '0;
        n_cmd    = 1'b0;
        priority if (r_step == STEP_PAGE) begin
            n_byte = CMD_PAGE | {4'd0, r_page};
            n_cmd  = 1'b1;
        end else if (r_step == STEP_COL_LO) begin
            n_byte = r_col & NIBBLE_LO;
            n_cmd  = 1'b1;
        end else if (r_step == STEP_COL_HI) begin
            n_byte = CMD_COL_HI | {4'd0, r_col[7:4]};
            n_cmd  = 1'b1;
        end else if (r_step < STEP_SPACER) begin
            // flip bit order of the stored column
            for (int b = 0; b < 8; b++) begin
                n_byte[b] = column[7 - b];
            end
        end else begin
            n_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_PAGE;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_step <= i_in.reposition ? STEP_PAGE : STEP_DATA;
        end else if (out_load && at_last) begin
            r_busy <= 1'b0;
        end else if (out_load) begin
            r_step <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page  <= i_in.page_addr;
            r_col   <= i_in.column_addr;
            r_glyph <= lookup.glyph;
            r_bad   <= lookup.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_byte <= n_byte;
            r_cmd  <= n_cmd;
            r_obad <= r_bad;
            r_last <= at_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_byte;
    assign o_out.is_command  = r_cmd;
    assign o_out.bad_code    = r_obad;
    assign o_out.last_of_run = r_last;

endmodule
`default_nettype wire

// ===== hdl/tgc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_port_checker
// Port-level checks of the text glyph column stream.
// ----------------------------------------------------------------------------
module tgc_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_cmd,
    input wire logic       i_out_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled byte changed");

    a_spacer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> !i_out_cmd && (i_out_byte == 8'h00))
        else $error("spacer is not a zero data byte");

    // a command byte is never the end of a run, so data must follow it
    a_cmd_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_cmd |=> i_out_valid && !i_out_last)
        else $error("run ended right after a command");

endmodule

bind text_glyph_column_stream tgc_port_checker u_tgc_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_cmd   (o_out.is_command),
    .i_out_last  (o_out.last_of_run)
);
`default_nettype wire
